FILE: hw/rtl/sict_pkg.sv
// sict_pkg: widths, register codes, reset values and shared types of the
// sphere in cone test unit; depends on nothing
package sict_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int RAD_W      = 31;
    localparam int LEN_W      = 31;
    localparam int TAN_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int ROOT_W     = COORD_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int DIV_STEPS  = QUO_W;

    localparam logic [LEN_W-1:0] CONE_LENGTH_RESET    = 31'd655360;
    localparam logic [TAN_W-1:0] TAN_HALF_ANGLE_RESET = 21'd5158;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONE_LENGTH    = 2'd0,
        CFG_TAN_HALF_ANGLE = 2'd1,
        CFG_GOD_MODE       = 2'd2
    } cfg_idx_t;

    // per item data carried alongside the root and quotient pipelines
    typedef struct packed {
        logic [2:0][DIFF_W-1:0]  d;
        logic [2:0][COORD_W-1:0] amag;
        logic [2:0]              aneg;
        logic [RAD_W-1:0]        radius;
        logic                    owner;
        logic                    zero_axis;
    } side_t;

endpackage

FILE: hw/rtl/sict_sqrt.sv
// sict_sqrt: pipelined integer square root, one root bit per stage
// depends on sict_pkg
module sict_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  sict_pkg::side_t              in_side,
    input  logic [sict_pkg::SQ_W-1:0]    in_sumsq,
    output logic                         out_valid,
    output sict_pkg::side_t              out_side,
    output logic [sict_pkg::ROOT_W-1:0]  out_root
);

    localparam int N   = sict_pkg::SQRT_STEPS;
    localparam int XW  = sict_pkg::SQ_W;
    localparam int RW  = sict_pkg::ROOT_W;
    localparam int MW  = RW + 2;
    localparam int WW  = RW + 4;

    logic [N-1:0]          vld_reg;
    sict_pkg::side_t       side_reg  [N];
    logic [XW-1:0]         x_reg     [N];
    logic [MW-1:0]         rem_reg   [N];
    logic [RW-1:0]         root_reg  [N];

    sict_pkg::side_t       side_next [N];
    logic [XW-1:0]         x_next    [N];
    logic [MW-1:0]         rem_next  [N];
    logic [RW-1:0]         root_next [N];

    logic [XW-1:0]         src_x     [N];
    logic [MW-1:0]         src_rem   [N];
    logic [RW-1:0]         src_root  [N];
    logic [WW-1:0]         work      [N];
    logic [WW-1:0]         trial     [N];
    logic [N-1:0]          ge;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                side_next[k] = in_side;
                src_x[k]     = in_sumsq;
                src_rem[k]   = '0;
                src_root[k]  = '0;
            end else begin
                side_next[k] = side_reg[k-1];
                src_x[k]     = x_reg[k-1];
                src_rem[k]   = rem_reg[k-1];
                src_root[k]  = root_reg[k-1];
            end
            work[k]      = {src_rem[k], src_x[k][XW-1:XW-2]};
            trial[k]     = {2'b00, src_root[k], 2'b01};
            ge[k]        = (work[k] >= trial[k]);
            rem_next[k]  = ge[k] ? MW'(work[k] - trial[k]) : MW'(work[k]);
            root_next[k] = {src_root[k][RW-2:0], ge[k]};
            x_next[k]    = {src_x[k][XW-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                side_reg[k] <= side_next[k];
                x_reg[k]    <= x_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_root  = root_reg[N-1];

endmodule

FILE: hw/rtl/sict_div.sv
// sict_div: three lane pipelined divider forming the unit axis, one quotient
// bit per stage; depends on sict_pkg
module sict_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  sict_pkg::side_t                      in_side,
    input  logic [sict_pkg::ROOT_W-1:0]          in_len,
    output logic                                 out_valid,
    output sict_pkg::side_t                      out_side,
    output logic [2:0][sict_pkg::QUO_W-1:0]      out_q
);

    localparam int N  = sict_pkg::DIV_STEPS;
    localparam int LW = sict_pkg::ROOT_W;
    localparam int QW = sict_pkg::QUO_W;
    localparam int CW = sict_pkg::COORD_W;

    logic [N-1:0]            vld_reg;
    sict_pkg::side_t         side_reg  [N];
    logic [LW-1:0]           len_reg   [N];
    logic [2:0][LW-1:0]      rem_reg   [N];
    logic [2:0][QW-1:0]      q_reg     [N];

    sict_pkg::side_t         side_next [N];
    logic [LW-1:0]           len_next  [N];
    logic [2:0][LW-1:0]      rem_next  [N];
    logic [2:0][QW-1:0]      q_next    [N];

    logic [2:0][LW-1:0]      src_rem   [N];
    logic [2:0][QW-1:0]      src_q     [N];
    logic [2:0]              bit_in    [N];
    logic [2:0][LW:0]        work      [N];
    logic [2:0]              ge        [N];

    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                side_next[k] = in_side;
                len_next[k]  = in_len;
                for (int j = 0; j < 3; j++) begin
                    src_rem[k][j] = {1'b0, in_side.amag[j][CW-1:1]};
                    src_q[k][j]   = '0;
                    bit_in[k][j]  = in_side.amag[j][0];
                end
            end else begin
                side_next[k] = side_reg[k-1];
                len_next[k]  = len_reg[k-1];
                for (int j = 0; j < 3; j++) begin
                    src_rem[k][j] = rem_reg[k-1][j];
                    src_q[k][j]   = q_reg[k-1][j];
                    bit_in[k][j]  = 1'b0;
                end
            end
            for (int j = 0; j < 3; j++) begin
                work[k][j]     = {src_rem[k][j], bit_in[k][j]};
                ge[k][j]       = (work[k][j] >= {1'b0, len_next[k]});
                rem_next[k][j] = ge[k][j] ? LW'(work[k][j] - {1'b0, len_next[k]})
                                          : work[k][j][LW-1:0];
                q_next[k][j]   = {src_q[k][j][QW-2:0], ge[k][j]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                side_reg[k] <= side_next[k];
                len_reg[k]  <= len_next[k];
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_q     = q_reg[N-1];

endmodule

FILE: hw/rtl/sphere_in_cone_test_unit.sv
// sphere_in_cone_test_unit: finite cone versus sphere hit test, top level
// depends on sict_pkg, sict_sqrt and sict_div
//
// One test is accepted every cycle and its hit bit is formed by, in order:
// three stages of difference, squaring and summing, 32 stages of the
// square root of the axis length (one root bit each), 17 stages of the
// three lane divider that forms the unit axis, and ten stages of dot
// product, range check, off-axis distance and compare, the last of them
// being the output register. The whole pipeline holds while a result waits.
// Configuration writes are taken at any time and must only be made while no
// item is in flight.
module sphere_in_cone_test_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sict_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sict_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_apex_x,
    input  logic signed [31:0]                  s_apex_y,
    input  logic signed [31:0]                  s_apex_z,
    input  logic signed [31:0]                  s_axis_x,
    input  logic signed [31:0]                  s_axis_y,
    input  logic signed [31:0]                  s_axis_z,
    input  logic signed [31:0]                  s_center_x,
    input  logic signed [31:0]                  s_center_y,
    input  logic signed [31:0]                  s_center_z,
    input  logic [30:0]                         s_sphere_radius,
    input  logic                                s_target_is_owner,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit
);

    localparam int F   = sict_pkg::FRAC_BITS;
    localparam int CW  = sict_pkg::COORD_W;
    localparam int DW  = sict_pkg::DIFF_W;
    localparam int SW  = sict_pkg::SQ_W;
    localparam int QW  = sict_pkg::QUO_W;
    localparam int UW  = QW + 1;
    localparam int PW  = UW + DW;
    localparam int DOTW = PW + 2;
    localparam int FWW = DOTW - 1 - F;
    localparam int FW  = 32;
    localparam int UFW = UW + FW + 1;
    localparam int FTW = FW + sict_pkg::TAN_W;
    localparam int TW  = UFW - F;
    localparam int EW  = TW + 1;
    localparam int RW  = FTW - F + 1;

    typedef struct packed {
        logic [2:0][DW-1:0]       d;
        logic [2:0][UW-1:0]       u;
        logic [sict_pkg::RAD_W-1:0] radius;
        logic                     owner;
        logic                     miss;
    } late_t;

    // configuration registers
    logic [sict_pkg::LEN_W-1:0] cone_length_reg;
    logic [sict_pkg::TAN_W-1:0] tan_half_angle_reg;
    logic                       god_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cone_length_reg    <= sict_pkg::CONE_LENGTH_RESET;
            tan_half_angle_reg <= sict_pkg::TAN_HALF_ANGLE_RESET;
            god_mode_reg       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (sict_pkg::cfg_idx_t'(cfg_index))
                sict_pkg::CFG_CONE_LENGTH: begin
                    cone_length_reg <= cfg_data;
                end
                sict_pkg::CFG_TAN_HALF_ANGLE: begin
                    tan_half_angle_reg <= cfg_data[sict_pkg::TAN_W-1:0];
                end
                sict_pkg::CFG_GOD_MODE: begin
                    god_mode_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    logic en;
    logic m_valid_reg;
    logic m_hit_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

    // stage 0: differences and axis magnitudes
    logic [2:0][CW-1:0] in_a, in_c, in_p;
    sict_pkg::side_t    p0_side_next, p0_side_reg;
    logic               p0_vld_reg;

    assign in_a = {s_axis_z, s_axis_y, s_axis_x};
    assign in_c = {s_center_z, s_center_y, s_center_x};
    assign in_p = {s_apex_z, s_apex_y, s_apex_x};

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            p0_side_next.d[j]    = {in_c[j][CW-1], in_c[j]} - {in_p[j][CW-1], in_p[j]};
            p0_side_next.amag[j] = in_a[j][CW-1] ? (CW'(0) - in_a[j]) : in_a[j];
            p0_side_next.aneg[j] = in_a[j][CW-1];
        end
        p0_side_next.radius    = s_sphere_radius;
        p0_side_next.owner     = s_target_is_owner;
        p0_side_next.zero_axis = (in_a == '0);
    end

    // stage 1: squares, stage 2: sum of squares
    logic               p1_vld_reg, p2_vld_reg;
    sict_pkg::side_t    p1_side_reg, p2_side_reg;
    logic [2:0][SW-1:0] p1_sq_reg;
    logic [SW-1:0]      p2_sumsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else if (en) begin
            p0_vld_reg <= s_valid;
            p1_vld_reg <= p0_vld_reg;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_side_reg <= p0_side_next;
            p1_side_reg <= p0_side_reg;
            for (int j = 0; j < 3; j++) begin
                p1_sq_reg[j] <= SW'(p0_side_reg.amag[j]) * SW'(p0_side_reg.amag[j]);
            end
            p2_side_reg  <= p1_side_reg;
            p2_sumsq_reg <= p1_sq_reg[0] + p1_sq_reg[1] + p1_sq_reg[2];
        end
    end

    // axis length and unit axis
    logic                           sq_vld;
    sict_pkg::side_t                sq_side;
    logic [sict_pkg::ROOT_W-1:0]    sq_root;
    logic                           dv_vld;
    sict_pkg::side_t                dv_side;
    logic [2:0][QW-1:0]             dv_q;

    sict_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_vld_reg),
        .in_side   (p2_side_reg),
        .in_sumsq  (p2_sumsq_reg),
        .out_valid (sq_vld),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    sict_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_vld),
        .in_side   (sq_side),
        .in_len    (sq_root),
        .out_valid (dv_vld),
        .out_side  (dv_side),
        .out_q     (dv_q)
    );

    // late stages
    logic [11:3] vld_reg;
    late_t       p3_next, p6_next;
    late_t       p3_reg, p4_reg, p5_reg, p6_reg, p7_reg, p8_reg, p9_reg;
    logic                  p10_owner_reg, p10_miss_reg, p11_owner_reg, p11_miss_reg;
    logic [2:0][PW-1:0]    p4_prod_reg;
    logic [DOTW-1:0]       p5_dot_reg;
    logic [FW-1:0]         p6_f_reg;
    logic [2:0][UFW-1:0]   p7_uf_reg;
    logic [FTW-1:0]        p7_ft_reg;
    logic [2:0][TW-1:0]    p8_t_reg;
    logic [RW-1:0]         p8_r_reg, p9_r_reg;
    logic [2:0][EW-1:0]    p9_emag_reg;
    logic [2:0][SW-1:0]    p10_esq_reg;
    logic [SW-1:0]         p10_rsq_reg;
    logic                  p11_le_reg;

    logic [FWW-1:0]        p6_fwide;
    logic [FW-1:0]         p6_limit;
    logic [2:0][UFW-1:0]   p8_bias;
    logic [2:0][UFW-1:0]   p8_sum;
    logic [2:0][EW-1:0]    p9_e;
    logic [SW+1:0]         p11_sum;
    logic [SW-1:0]         p11_dist;

    function automatic logic [SW-1:0] sat_square(input logic [RW-1:0] m);
        logic [SW-1:0] res;
        if (m[RW-1:CW] != '0) begin
            res = '1;
        end else begin
            res = SW'(m[CW-1:0]) * SW'(m[CW-1:0]);
        end
        return res;
    endfunction

    always_comb begin
        p3_next.d      = dv_side.d;
        p3_next.radius = dv_side.radius;
        p3_next.owner  = dv_side.owner;
        p3_next.miss   = dv_side.zero_axis;
        for (int j = 0; j < 3; j++) begin
            p3_next.u[j] = dv_side.aneg[j] ? (UW'(0) - UW'(dv_q[j])) : UW'(dv_q[j]);
        end
        p6_fwide = p5_dot_reg[DOTW-2:F];
        p6_limit = FW'(p5_reg.radius) + FW'(cone_length_reg);
        p6_next      = p5_reg;
        p6_next.miss = p5_reg.miss || p5_dot_reg[DOTW-1]
                     || (p6_fwide > FWW'(p6_limit));
        for (int j = 0; j < 3; j++) begin
            p8_bias[j] = p7_uf_reg[j][UFW-1] ? UFW'((1 << F) - 1) : '0;
            p8_sum[j]  = p7_uf_reg[j] + p8_bias[j];
            p9_e[j]    = {{(EW-DW){p8_reg.d[j][DW-1]}}, p8_reg.d[j]}
                       - {p8_t_reg[j][TW-1], p8_t_reg[j]};
        end
        p11_sum  = (SW+2)'(p10_esq_reg[0]) + (SW+2)'(p10_esq_reg[1])
                 + (SW+2)'(p10_esq_reg[2]);
        p11_dist = (p11_sum[SW+1:SW] != 2'b00) ? '1 : p11_sum[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[10:3], dv_vld};
            m_valid_reg <= vld_reg[11];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_reg <= p3_next;

            p4_reg <= p3_reg;
            for (int j = 0; j < 3; j++) begin
                p4_prod_reg[j] <= PW'($signed(p3_reg.u[j])) * PW'($signed(p3_reg.d[j]));
            end

            p5_reg     <= p4_reg;
            p5_dot_reg <= DOTW'($signed(p4_prod_reg[0])) + DOTW'($signed(p4_prod_reg[1]))
                        + DOTW'($signed(p4_prod_reg[2]));

            p6_reg      <= p6_next;
            p6_f_reg    <= p6_fwide[FW-1:0];

            p7_reg <= p6_reg;
            for (int j = 0; j < 3; j++) begin
                p7_uf_reg[j] <= UFW'($signed(p6_reg.u[j])) * UFW'({1'b0, p6_f_reg});
            end
            p7_ft_reg <= FTW'(p6_f_reg) * FTW'(tan_half_angle_reg);

            p8_reg <= p7_reg;
            for (int j = 0; j < 3; j++) begin
                p8_t_reg[j] <= p8_sum[j][UFW-1:F];
            end
            p8_r_reg <= RW'(p7_reg.radius) + RW'(p7_ft_reg[FTW-1:F]);

            p9_reg <= p8_reg;
            p9_r_reg <= p8_r_reg;
            for (int j = 0; j < 3; j++) begin
                p9_emag_reg[j] <= p9_e[j][EW-1] ? (EW'(0) - p9_e[j]) : p9_e[j];
            end

            p10_owner_reg <= p9_reg.owner;
            p10_miss_reg  <= p9_reg.miss;
            for (int j = 0; j < 3; j++) begin
                p10_esq_reg[j] <= sat_square(RW'(p9_emag_reg[j]));
            end
            p10_rsq_reg <= sat_square(p9_r_reg);

            p11_owner_reg <= p10_owner_reg;
            p11_miss_reg  <= p10_miss_reg;
            p11_le_reg    <= (p11_dist <= p10_rsq_reg);

            if (p11_owner_reg) begin
                m_hit_reg <= 1'b0;
            end else if (god_mode_reg) begin
                m_hit_reg <= 1'b1;
            end else begin
                m_hit_reg <= !p11_miss_reg && p11_le_reg;
            end
        end
    end

endmodule
